// File: rtl/core/tlhc_pkg.sv
// Package for the tuple lane hash combiner: word types, hash constants,
// mode codes and the response bundle of the shared multiplier.
// No dependencies.
`default_nettype none

package tlhc_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned LEN_W  = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Hash mode register codes
  localparam logic MODE_XX     = 1'b0;
  localparam logic MODE_LEGACY = 1'b1;

  // Accumulator rule primes, wide and narrow variants
  localparam word_t XX64_P1 = 64'd11400714785074694791;
  localparam word_t XX64_P2 = 64'd14029467366897019727;
  localparam word_t XX64_P5 = 64'd2870177450012600261;
  localparam word_t XX32_P1 = 64'd2654435761;
  localparam word_t XX32_P2 = 64'd2246822519;
  localparam word_t XX32_P5 = 64'd374761393;
  localparam word_t XX_LEN_MANGLE  = 64'd3527539;
  localparam word_t XX_ALLONES_SUB = 64'd1546275796;

  // Legacy multiplicative rule constants
  localparam word_t LG_MULT0     = 64'd1000003;
  localparam word_t LG_MULT_STEP = 64'd82520;
  localparam word_t LG_SEED      = 64'h345678;
  localparam word_t LG_FINAL_ADD = 64'd97531;

  // Status of the shared multiplier towards the sequencer
  typedef struct packed {
    logic  done;
    word_t product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/tlhc_if.sv
// Valid/ready channel interfaces of the tuple lane hash combiner:
// one for lane items in, one for tuple results out. Uses tlhc_pkg.
`default_nettype none

interface tlhc_in_if;
  import tlhc_pkg::*;
  logic  valid;
  logic  ready;
  logic  first_of_tuple;
  len_t  tuple_length;
  word_t lane_hash;

  modport source (output valid, first_of_tuple, tuple_length, lane_hash, input ready);
  modport sink   (input valid, first_of_tuple, tuple_length, lane_hash, output ready);
endinterface

interface tlhc_out_if;
  import tlhc_pkg::*;
  logic  valid;
  logic  ready;
  word_t tuple_hash;
  logic  hash_error;

  modport source (output valid, tuple_hash, hash_error, input ready);
  modport sink   (input valid, tuple_hash, hash_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlhc_mul.sv
// Shared 64x64 (low half) multiplier built from one registered 32x32 unit,
// three partial products, summed in steps LL, LH, HL, SUM. Uses tlhc_pkg.
`default_nettype none

module tlhc_mul import tlhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  word_t    op_a_i,
  input  word_t    op_b_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] STEP_LL  = 2'd0;
  localparam logic [1:0] STEP_LH  = 2'd1;
  localparam logic [1:0] STEP_HL  = 2'd2;
  localparam logic [1:0] STEP_SUM = 2'd3;

  logic       busy_q;
  logic [1:0] step_q;
  logic       done_q;
  half_t      sel_a;
  half_t      sel_b;
  word_t      part_d;
  word_t      part_q;
  word_t      sum_q;

  // Pick the operand halves for this step
  always_comb begin
    case (step_q)
      STEP_LL: begin
        sel_a = op_a_i[HALF_W-1:0];
        sel_b = op_b_i[HALF_W-1:0];
      end
      STEP_LH: begin
        sel_a = op_a_i[HALF_W-1:0];
        sel_b = op_b_i[WORD_W-1:HALF_W];
      end
      default: begin
        sel_a = op_a_i[WORD_W-1:HALF_W];
        sel_b = op_b_i[HALF_W-1:0];
      end
    endcase
  end

  assign part_d = word_t'(sel_a) * word_t'(sel_b);

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_LL;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_LL;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == STEP_SUM) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Register one partial product a cycle and fold the previous one in
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      part_q <= part_d;
      case (step_q)
        STEP_LH:  sum_q <= part_q;
        STEP_HL,
        STEP_SUM: sum_q <= sum_q + (part_q << HALF_W);
        default:  sum_q <= sum_q;
      endcase
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = sum_q;

endmodule

`default_nettype wire

// File: rtl/core/tuple_lane_hash_combiner_top.sv
// Tuple lane hash combiner: in sequencer, operand registers, final mix.
// Depends on tlhc_pkg, tlhc_if (channel interfaces) and tlhc_mul.
//
// Usage:
//  - in_if carries one lane per transfer. first_of_tuple = 1 opens a tuple,
//    samples tuple_length (saturated to MAX_LANES) and, for a non-empty
//    tuple, carries the first lane. Lanes with no open tuple are dropped.
//  - out_if gives one result per finished tuple: tuple_hash and hash_error.
//    A zero length tuple gives its result straight away.
//  - cfg_we_i/cfg_wdata_i write hash_mode; write only while no tuple is open.
//  - Each 64-bit multiply runs on one shared 32x32 unit. A lane takes one
//    multiply in legacy mode and two dependent multiplies in accumulator
//    mode; a lane that starts no multiply, or an all-ones lane, takes
//    none. A finishing lane then passes through S_EMIT to load the output
//    register. in_if.ready is low while a lane is being worked on.
//  - The output register holds a result until taken; the next lane is
//    accepted meanwhile, and only the following result waits for it.
//  - Reset clears the mode to the accumulator rule, closes any tuple and
//    drops a pending result.
`default_nettype none

module tuple_lane_hash_combiner_top import tlhc_pkg::*; #(
  parameter int unsigned HASH_WIDTH = 64,
  parameter int unsigned MAX_LANES  = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  tlhc_in_if.sink           in_if,
  tlhc_out_if.source        out_if
);

  localparam int unsigned HW = HASH_WIDTH;
  localparam logic [HW-1:0] HMASK = {HW{1'b1}};
  localparam logic [HW-1:0] XX_P1 = (HW > 32) ? XX64_P1[HW-1:0] : XX32_P1[HW-1:0];
  localparam logic [HW-1:0] XX_P2 = (HW > 32) ? XX64_P2[HW-1:0] : XX32_P2[HW-1:0];
  localparam logic [HW-1:0] XX_P5 = (HW > 32) ? XX64_P5[HW-1:0] : XX32_P5[HW-1:0];
  localparam int unsigned   XX_ROT = (HW > 32) ? 31 : 13;
  localparam len_t          MAX_LEN = LEN_W'(MAX_LANES);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          mode_q;
  logic [HW-1:0] acc_q, acc_d;
  logic [HW-1:0] mult_q, mult_d;
  logic [HW-1:0] opa_q, opa_d;
  logic [HW-1:0] opb_q, opb_d;
  len_t          lanes_q, lanes_d;
  len_t          total_q, total_d;
  logic          err_q, err_d;
  logic          in_tuple_q, in_tuple_d;
  logic          last_q, last_d;
  logic          start_q, start_d;
  logic          out_valid_q, out_valid_d;
  word_t         out_hash_q, out_hash_d;
  logic          out_err_q, out_err_d;

  logic          in_fire;
  len_t          len_sat;
  logic [HW-1:0] lane;
  logic [HW-1:0] fin_hash;
  logic [HW-1:0] mix_sum;
  logic [HW-1:0] mix_rot;
  mul_rsp_t      mul_rsp;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign len_sat     = (in_if.tuple_length > MAX_LEN) ? MAX_LEN : in_if.tuple_length;
  assign lane        = in_if.lane_hash[HW-1:0];

  // Shared multiplier
  tlhc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .op_a_i  (word_t'(opa_q)),
    .op_b_i  (word_t'(opb_q)),
    .rsp_o   (mul_rsp)
  );

  // Accumulator rule: add, rotate, then into the second multiply
  assign mix_sum = acc_q + mul_rsp.product[HW-1:0];
  assign mix_rot = (mix_sum << XX_ROT) | (mix_sum >> (HW - XX_ROT));

  // Final mix of the tuple result
  always_comb begin : p_final
    logic [HW-1:0] h;
    h = '0;
    if (err_q) begin
      fin_hash = HMASK;
    end else if (mode_q == MODE_XX) begin
      h = acc_q + ({{(HW-LEN_W){1'b0}}, total_q} ^ (XX_P5 ^ XX_LEN_MANGLE[HW-1:0]));
      fin_hash = (h == HMASK) ? XX_ALLONES_SUB[HW-1:0] : h;
    end else begin
      h = acc_q + LG_FINAL_ADD[HW-1:0];
      fin_hash = (h == HMASK) ? (HMASK - {{(HW-1){1'b0}}, 1'b1}) : h;
    end
  end

  // Sequencer next state
  always_comb begin : p_next
    logic [HW-1:0] base_acc;
    logic [HW-1:0] base_mult;
    len_t          base_lanes;
    len_t          lanes_dec;
    logic          base_err;
    logic          take;

    state_d     = state_q;
    acc_d       = acc_q;
    mult_d      = mult_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    lanes_d     = lanes_q;
    total_d     = total_q;
    err_d       = err_q;
    in_tuple_d  = in_tuple_q;
    last_d      = last_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    out_hash_d  = out_hash_q;
    out_err_d   = out_err_q;

    base_acc    = acc_q;
    base_mult   = mult_q;
    base_lanes  = lanes_q;
    base_err    = err_q;
    take        = in_tuple_q;
    lanes_dec   = lanes_q;

    // Drop the result once transferred
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Open a new tuple and load the start values
          if (in_if.first_of_tuple) begin
            total_d    = len_sat;
            base_lanes = len_sat;
            base_acc   = (mode_q == MODE_XX) ? XX_P5 : LG_SEED[HW-1:0];
            base_mult  = LG_MULT0[HW-1:0];
            base_err   = 1'b0;
            acc_d      = base_acc;
            mult_d     = base_mult;
            err_d      = 1'b0;
            lanes_d    = len_sat;
            if (len_sat == '0) begin
              in_tuple_d = 1'b0;
              take       = 1'b0;
              state_d    = S_EMIT;
            end else begin
              in_tuple_d = 1'b1;
              take       = 1'b1;
            end
          end
          // Take the lane in
          if (take) begin
            lanes_dec = base_lanes - LEN_W'(1);
            lanes_d   = lanes_dec;
            last_d    = (lanes_dec == '0);
            if (lanes_dec == '0) begin
              in_tuple_d = 1'b0;
            end
            if (!base_err && (lane != HMASK)) begin
              start_d = 1'b1;
              state_d = S_MUL1;
              if (mode_q == MODE_XX) begin
                opa_d = lane;
                opb_d = XX_P2;
              end else begin
                opa_d  = base_acc ^ lane;
                opb_d  = base_mult;
                mult_d = base_mult + LG_MULT_STEP[HW-1:0]
                       + {{(HW-LEN_W-1){1'b0}}, lanes_dec, 1'b0};
              end
            end else begin
              if (lane == HMASK) begin
                err_d = 1'b1;
              end
              state_d = (lanes_dec == '0) ? S_EMIT : S_IDLE;
            end
          end
        end
      end
      S_MUL1: begin
        if (mul_rsp.done) begin
          if (mode_q == MODE_XX) begin
            opa_d   = mix_rot;
            opb_d   = XX_P1;
            start_d = 1'b1;
            state_d = S_MUL2;
          end else begin
            acc_d   = mul_rsp.product[HW-1:0];
            state_d = last_q ? S_EMIT : S_IDLE;
          end
        end
      end
      S_MUL2: begin
        if (mul_rsp.done) begin
          acc_d   = mul_rsp.product[HW-1:0];
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        // Load the output register once it is free
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_hash_d  = word_t'(fin_hash);
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_XX;
      lanes_q     <= '0;
      err_q       <= 1'b0;
      in_tuple_q  <= 1'b0;
      last_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lanes_q     <= lanes_d;
      err_q       <= err_d;
      in_tuple_q  <= in_tuple_d;
      last_q      <= last_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    mult_q     <= mult_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    total_q    <= total_d;
    out_hash_q <= out_hash_d;
    out_err_q  <= out_err_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.tuple_hash = out_hash_q;
  assign out_if.hash_error = out_err_q;

endmodule

`default_nettype wire

// File: rtl/core/tlhc_checker.sv
// Port-level checks for the tuple lane hash combiner and the bind that
// attaches them to tuple_lane_hash_combiner_top. Uses tlhc_pkg.
`default_nettype none

module tlhc_checker import tlhc_pkg::*; #(
  parameter int unsigned HASH_WIDTH = 64
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  out_valid_i,
  input wire logic  out_ready_i,
  input wire word_t tuple_hash_i,
  input wire logic  hash_error_i
);

  localparam word_t HMASK = word_t'({HASH_WIDTH{1'b1}});

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Error results carry the all-ones word
  a_err_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hash_error_i |-> tuple_hash_i == HMASK)
    else $error("error result is not all ones");

  // A good result never equals the error word
  a_ok_not_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hash_error_i |-> tuple_hash_i != HMASK)
    else $error("good result equals the error word");

  // Bits above the hash width stay clear
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (tuple_hash_i & ~HMASK) == '0)
    else $error("result bits above hash width set");

endmodule

bind tuple_lane_hash_combiner_top tlhc_checker #(
  .HASH_WIDTH (HASH_WIDTH)
) u_tlhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .tuple_hash_i (out_if.tuple_hash),
  .hash_error_i (out_if.hash_error)
);

`default_nettype wire
